>>> rtl/least_loaded_server_registry_unit_defines.svh
// Assertion helpers used by the checker.
`ifndef LEAST_LOADED_SERVER_REGISTRY_UNIT_DEFINES_SVH
`define LEAST_LOADED_SERVER_REGISTRY_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LLSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/llsr_pkg.sv
package llsr_pkg;

  localparam int ActW  = 3;
  localparam int AddrW = 32;
  localparam int PortW = 16;
  localparam int LoadW = 16;
  localparam int StatW = 2;
  localparam int RemW  = 5;

  localparam logic [LoadW-1:0] LoadMax = '1;

  typedef enum logic [ActW-1:0] {
    ACT_REGISTER   = 3'd0,
    ACT_HEARTBEAT  = 3'd1,
    ACT_DEREGISTER = 3'd2,
    ACT_LOAD_UP    = 3'd3,
    ACT_LOAD_DOWN  = 3'd4,
    ACT_SWEEP      = 3'd5,
    ACT_PICK       = 3'd6
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FIRST = 2'd1,
    STAT_FAIL  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_SWEEP,
    ST_MIN,
    ST_PSEL,
    ST_PREAD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic match;
    logic exec;
    logic sw_start;
    logic sw_step;
    logic sw_finish;
    logic min_start;
    logic min_step;
    logic pick_sel;
    logic pick_read;
    logic publish;
  } llsr_cmd_t;

  typedef struct packed {
    action_e action;
    logic    count_zero;
    logic    scan_done;
  } llsr_stat_t;

endpackage

>>> rtl/least_loaded_server_registry_unit.sv
// Channel  Handshake               Word
// in       in_valid_i / in_ready_o  action_i, server_address_i, server_port_i
// out      out_valid_o / out_ready_i status_o, picked_address_o, picked_port_o,
//                                   removed_count_o
//
// One action at a time. Register, heartbeat, deregister, load up/down and
// unknown codes pass lookup, exec and response; a sweep scans the table; a
// pick scans for the minimum load, then selects and reads the entry, or takes
// exec on an empty table. Both scans walk one table entry per cycle.
// The result sits in an output register; a stalled output holds the next
// action in its final state until the register frees up.
// Reset (rst_ni, async low) empties the table; no clearing pass.
module least_loaded_server_registry_unit #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [llsr_pkg::ActW-1:0]   action_i,
  input  logic [llsr_pkg::AddrW-1:0]  server_address_i,
  input  logic [llsr_pkg::PortW-1:0]  server_port_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [llsr_pkg::StatW-1:0]  status_o,
  output logic [llsr_pkg::AddrW-1:0]  picked_address_o,
  output logic [llsr_pkg::PortW-1:0]  picked_port_o,
  output logic [llsr_pkg::RemW-1:0]   removed_count_o
);
  import llsr_pkg::*;

  llsr_cmd_t  cmd;
  llsr_stat_t stat;

  llsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  llsr_table #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_table (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .server_address_i (server_address_i),
    .server_port_i    (server_port_i),
    .status_o         (status_o),
    .picked_address_o (picked_address_o),
    .picked_port_o    (picked_port_o),
    .removed_count_o  (removed_count_o)
  );

endmodule

>>> rtl/llsr_ctrl.sv
module llsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  llsr_pkg::llsr_stat_t stat_i,
  output llsr_pkg::llsr_cmd_t  cmd_o
);
  import llsr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        case (stat_i.action)
          ACT_SWEEP: state_d = ST_SWEEP;
          ACT_PICK:  state_d = stat_i.count_zero ? ST_EXEC : ST_MIN;
          default:   state_d = ST_EXEC;
        endcase
      end
      ST_EXEC:  state_d = ST_RESP;
      ST_SWEEP: begin
        if (stat_i.scan_done) state_d = ST_RESP;
      end
      ST_MIN: begin
        if (stat_i.scan_done) state_d = ST_PSEL;
      end
      ST_PSEL:  state_d = ST_PREAD;
      ST_PREAD: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.latch = in_valid_i;
      ST_LOOKUP: begin
        cmd_o.match     = 1'b1;
        cmd_o.sw_start  = (stat_i.action == ACT_SWEEP);
        cmd_o.min_start = (stat_i.action == ACT_PICK) && !stat_i.count_zero;
      end
      ST_EXEC:   cmd_o.exec = 1'b1;
      ST_SWEEP: begin
        cmd_o.sw_finish = stat_i.scan_done;
        cmd_o.sw_step   = !stat_i.scan_done;
      end
      ST_MIN:    cmd_o.min_step = !stat_i.scan_done;
      ST_PSEL:   cmd_o.pick_sel = 1'b1;
      ST_PREAD:  cmd_o.pick_read = 1'b1;
      ST_RESP:   cmd_o.publish = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/llsr_table.sv
module llsr_table #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  llsr_pkg::llsr_cmd_t         cmd_i,
  output llsr_pkg::llsr_stat_t        stat_o,
  input  logic [llsr_pkg::ActW-1:0]   action_i,
  input  logic [llsr_pkg::AddrW-1:0]  server_address_i,
  input  logic [llsr_pkg::PortW-1:0]  server_port_i,
  output logic [llsr_pkg::StatW-1:0]  status_o,
  output logic [llsr_pkg::AddrW-1:0]  picked_address_o,
  output logic [llsr_pkg::PortW-1:0]  picked_port_o,
  output logic [llsr_pkg::RemW-1:0]   removed_count_o
);
  import llsr_pkg::*;

  localparam int IdxW = $clog2(MAX_SERVERS);
  localparam int CntW = $clog2(MAX_SERVERS + 1);

  // latched request word
  action_e          act_q;
  logic [AddrW-1:0] addr_q;
  logic [PortW-1:0] port_q;

  // server table, valid entries form a prefix of length cnt_q
  logic [AddrW-1:0] ent_addr_q  [MAX_SERVERS];
  logic [PortW-1:0] ent_port_q  [MAX_SERVERS];
  logic [LoadW-1:0] ent_load_q  [MAX_SERVERS];
  logic             ent_alive_q [MAX_SERVERS];

  logic [CntW-1:0]  cnt_q;
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic [CntW-1:0]  scan_q;
  logic [CntW-1:0]  removed_q;
  logic [LoadW-1:0] min_q;

  status_e          res_status_q;
  logic [AddrW-1:0] res_addr_q;
  logic [PortW-1:0] res_port_q;
  logic [RemW-1:0]  res_removed_q;

  status_e          out_status_q;
  logic [AddrW-1:0] out_addr_q;
  logic [PortW-1:0] out_port_q;
  logic [RemW-1:0]  out_removed_q;

  logic [MAX_SERVERS-1:0] cam_vec;
  logic                   cam_hit;
  logic [IdxW-1:0]        cam_idx;

  logic [IdxW-1:0]  scan_idx;
  logic             scan_alive;
  logic             scan_done;
  logic             cnt_full;
  logic [LoadW-1:0] hit_load;
  logic             reg_ok;
  logic             shift_en;
  logic [IdxW-1:0]  shift_idx;
  status_e          exec_status;

  assign scan_idx   = scan_q[IdxW-1:0];
  assign scan_alive = ent_alive_q[scan_idx];
  assign scan_done  = (scan_q >= cnt_q);
  assign cnt_full   = (cnt_q == CntW'(MAX_SERVERS));
  assign hit_load   = ent_load_q[hit_idx_q];
  assign reg_ok     = cmd_i.exec && (act_q == ACT_REGISTER) && !hit_q && !cnt_full;
  assign shift_en   = (cmd_i.exec && (act_q == ACT_DEREGISTER) && hit_q) ||
                      (cmd_i.sw_step && !scan_alive);
  assign shift_idx  = cmd_i.exec ? hit_idx_q : scan_idx;

  assign stat_o.action     = act_q;
  assign stat_o.count_zero = (cnt_q == '0);
  assign stat_o.scan_done  = scan_done;

  // per-entry compare, first match wins
  always_comb begin
    cam_vec = '0;
    for (int j = 0; j < MAX_SERVERS; j++) begin
      if (cmd_i.pick_sel) begin
        cam_vec[j] = (CntW'(j) < cnt_q) && ent_alive_q[j] && (ent_load_q[j] == min_q);
      end else begin
        cam_vec[j] = (CntW'(j) < cnt_q) && (ent_addr_q[j] == addr_q) &&
                     (ent_port_q[j] == port_q);
      end
    end
    cam_hit = |cam_vec;
    cam_idx = '0;
    for (int j = MAX_SERVERS - 1; j >= 0; j--) begin
      if (cam_vec[j]) cam_idx = IdxW'(j);
    end
  end

  always_comb begin
    case (act_q)
      ACT_REGISTER: begin
        if (hit_q) begin
          exec_status = STAT_FAIL;
        end else if (cnt_full) begin
          exec_status = STAT_FULL;
        end else if (cnt_q == '0) begin
          exec_status = STAT_FIRST;
        end else begin
          exec_status = STAT_OK;
        end
      end
      ACT_HEARTBEAT, ACT_DEREGISTER, ACT_LOAD_UP, ACT_LOAD_DOWN: begin
        exec_status = hit_q ? STAT_OK : STAT_FAIL;
      end
      default: exec_status = STAT_FAIL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
      scan_q    <= '0;
      removed_q <= '0;
    end else begin
      if (cmd_i.match || cmd_i.pick_sel) begin
        hit_q     <= cam_hit;
        hit_idx_q <= cam_idx;
      end
      if (reg_ok) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (shift_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.sw_start) begin
        scan_q    <= '0;
        removed_q <= '0;
      end
      if (cmd_i.min_start) scan_q <= CntW'(1);
      if (cmd_i.sw_step) begin
        if (!scan_alive) begin
          removed_q <= removed_q + CntW'(1);
        end else begin
          scan_q <= scan_q + CntW'(1);
        end
      end
      if (cmd_i.min_step) scan_q <= scan_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_e'(action_i);
      addr_q <= server_address_i;
      port_q <= server_port_i;
    end
    if (cmd_i.min_start) min_q <= ent_load_q[0];
    if (cmd_i.min_step && (ent_load_q[scan_idx] < min_q)) min_q <= ent_load_q[scan_idx];

    if (cmd_i.exec) begin
      res_status_q  <= exec_status;
      res_addr_q    <= '0;
      res_port_q    <= '0;
      res_removed_q <= '0;
    end
    if (cmd_i.sw_finish) begin
      res_status_q  <= (removed_q != '0) ? STAT_OK : STAT_FAIL;
      res_addr_q    <= '0;
      res_port_q    <= '0;
      res_removed_q <= RemW'(removed_q);
    end
    if (cmd_i.pick_read) begin
      res_status_q  <= hit_q ? STAT_OK : STAT_FAIL;
      res_addr_q    <= hit_q ? ent_addr_q[hit_idx_q] : '0;
      res_port_q    <= hit_q ? ent_port_q[hit_idx_q] : '0;
      res_removed_q <= '0;
    end
    if (cmd_i.publish) begin
      out_status_q  <= res_status_q;
      out_addr_q    <= res_addr_q;
      out_port_q    <= res_port_q;
      out_removed_q <= res_removed_q;
    end

    // close the gap at shift_idx
    if (shift_en) begin
      for (int j = 0; j < MAX_SERVERS - 1; j++) begin
        if (IdxW'(j) >= shift_idx) begin
          ent_addr_q[j]  <= ent_addr_q[j+1];
          ent_port_q[j]  <= ent_port_q[j+1];
          ent_load_q[j]  <= ent_load_q[j+1];
          ent_alive_q[j] <= ent_alive_q[j+1];
        end
      end
    end
    if (reg_ok) begin
      ent_addr_q[cnt_q[IdxW-1:0]]  <= addr_q;
      ent_port_q[cnt_q[IdxW-1:0]]  <= port_q;
      ent_load_q[cnt_q[IdxW-1:0]]  <= '0;
      ent_alive_q[cnt_q[IdxW-1:0]] <= 1'b1;
    end
    if (cmd_i.exec && hit_q) begin
      case (act_q)
        ACT_HEARTBEAT: ent_alive_q[hit_idx_q] <= 1'b1;
        ACT_LOAD_UP: begin
          if (hit_load != LoadMax) ent_load_q[hit_idx_q] <= hit_load + LoadW'(1);
        end
        ACT_LOAD_DOWN: begin
          if (hit_load != '0) ent_load_q[hit_idx_q] <= hit_load - LoadW'(1);
        end
        default: ;
      endcase
    end
    if (cmd_i.sw_step && scan_alive) ent_alive_q[scan_idx] <= 1'b0;
  end

  assign status_o         = out_status_q;
  assign picked_address_o = out_addr_q;
  assign picked_port_o    = out_port_q;
  assign removed_count_o  = out_removed_q;

endmodule

>>> rtl/llsr_checker.sv
`include "least_loaded_server_registry_unit_defines.svh"

module llsr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [llsr_pkg::StatW-1:0]  status_o,
  input logic [llsr_pkg::AddrW-1:0]  picked_address_o,
  input logic [llsr_pkg::PortW-1:0]  picked_port_o,
  input logic [llsr_pkg::RemW-1:0]   removed_count_o
);
  import llsr_pkg::*;

  `LLSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(picked_address_o) && $stable(picked_port_o) && $stable(removed_count_o), "output word changed while stalled")
  `LLSR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after an accepted word")
  `LLSR_ASSERT_SAME(a_removed_ok, clk_i, rst_ni, out_valid_o && (removed_count_o != '0), status_o == STAT_OK, "nonzero removed count without ok status")
  `LLSR_ASSERT_SAME(a_pick_ok, clk_i, rst_ni, out_valid_o && ((picked_address_o != '0) || (picked_port_o != '0)), status_o == STAT_OK, "picked server without ok status")

endmodule

bind least_loaded_server_registry_unit llsr_checker u_llsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .picked_address_o (picked_address_o),
  .picked_port_o    (picked_port_o),
  .removed_count_o  (removed_count_o)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import llsr_pkg::*;

  localparam int MaxServers = 16;
  localparam int PoolSize = 24;
  localparam int RandomWords = 1675;
  localparam int LoadBurst = 32;
  localparam int DrainCycles = 64;
  localparam int unsigned CycleLimit = 2000000;
  localparam logic [ActW-1:0] ActReserved = 3'd7;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] addr;
    logic [PortW-1:0] port;
    logic [RemW-1:0]  removed;
  } outcome_t;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [AddrW-1:0] addr;
    logic [PortW-1:0] port;
    logic             typed;
    outcome_t         want;
  } plan_row_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [PortW-1:0] port;
  } server_t;

  localparam outcome_t NoWord    = '0;
  localparam outcome_t FailWord  = '{STAT_FAIL, 32'h0, 16'h0, 5'd0};
  localparam outcome_t OkWord    = '{STAT_OK, 32'h0, 16'h0, 5'd0};
  localparam outcome_t FirstWord = '{STAT_FIRST, 32'h0, 16'h0, 5'd0};

  // directed words; typed rows carry the obvious answer, the rest use the predictor
  localparam plan_row_t PlanRows [25] = '{
    '{ACT_PICK,       32'h0000_0000, 16'h0000, 1'b1, FailWord},
    '{ACT_SWEEP,      32'h0000_0000, 16'h0000, 1'b1, FailWord},
    '{ACT_HEARTBEAT,  32'h0A00_0001, 16'h0050, 1'b1, FailWord},
    '{ACT_REGISTER,   32'h0000_0000, 16'h0000, 1'b1, FirstWord},
    '{ACT_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, OkWord},
    '{ACT_REGISTER,   32'hFFFF_FFFF, 16'hFFFF, 1'b1, FailWord},
    '{ACT_REGISTER,   32'h0000_0000, 16'hFFFF, 1'b1, OkWord},
    '{ACT_REGISTER,   32'hFFFF_FFFF, 16'h0000, 1'b1, OkWord},
    '{ACT_LOAD_UP,    32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_LOAD_DOWN,  32'h0000_0000, 16'hFFFF, 1'b0, NoWord},
    '{ACT_PICK,       32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_HEARTBEAT,  32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_DEREGISTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, NoWord},
    '{ACT_DEREGISTER, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, FailWord},
    '{ACT_LOAD_UP,    32'h1234_5678, 16'h0001, 1'b1, FailWord},
    '{ACT_LOAD_DOWN,  32'h1234_5678, 16'h0001, 1'b1, FailWord},
    '{ActReserved,    32'h0000_0000, 16'h0000, 1'b1, FailWord},
    '{ACT_SWEEP,      32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_PICK,       32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_HEARTBEAT,  32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_PICK,       32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_SWEEP,      32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_PICK,       32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_DEREGISTER, 32'h0000_0000, 16'h0000, 1'b0, NoWord},
    '{ACT_REGISTER,   32'hA55A_5AA5, 16'h5AA5, 1'b1, FirstWord}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [ActW-1:0] action_i;
  logic [AddrW-1:0] server_address_i;
  logic [PortW-1:0] server_port_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [StatW-1:0] status_o;
  logic [AddrW-1:0] picked_address_o;
  logic [PortW-1:0] picked_port_o;
  logic [RemW-1:0] removed_count_o;

  int tbl_used;
  logic [AddrW-1:0] tbl_addr [MaxServers];
  logic [PortW-1:0] tbl_port [MaxServers];
  logic [LoadW-1:0] tbl_load [MaxServers];
  logic             tbl_alive [MaxServers];

  outcome_t pending_q [$];
  server_t pool [PoolSize];
  bit src_idle;
  bit sink_idle;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned full_hits = 0;
  int unsigned removed_total = 0;
  int unsigned picks_found = 0;
  int unsigned cycle_count = 0;

  least_loaded_server_registry_unit #(
    .MAX_SERVERS(MaxServers)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .server_address_i(server_address_i),
    .server_port_i   (server_port_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .picked_address_o(picked_address_o),
    .picked_port_o   (picked_port_o),
    .removed_count_o (removed_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic outcome_t registry_apply(logic [ActW-1:0] act, logic [AddrW-1:0] addr,
                                              logic [PortW-1:0] port);
    outcome_t o;
    int hit;
    int keep;
    int removed;
    logic [LoadW-1:0] low;
    o = FailWord;
    hit = -1;
    keep = 0;
    removed = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_addr[i] == addr && tbl_port[i] == port) hit = i;
    end
    case (act)
      ACT_REGISTER: begin
        if (hit >= 0) begin
          o.status = STAT_FAIL;
        end else if (tbl_used >= MaxServers) begin
          o.status = STAT_FULL;
        end else begin
          tbl_addr[tbl_used] = addr;
          tbl_port[tbl_used] = port;
          tbl_load[tbl_used] = '0;
          tbl_alive[tbl_used] = 1'b1;
          o.status = (tbl_used == 0) ? STAT_FIRST : STAT_OK;
          tbl_used++;
        end
      end
      ACT_HEARTBEAT: begin
        if (hit >= 0) begin
          tbl_alive[hit] = 1'b1;
          o.status = STAT_OK;
        end
      end
      ACT_DEREGISTER: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < tbl_used; i++) begin
            tbl_addr[i] = tbl_addr[i+1];
            tbl_port[i] = tbl_port[i+1];
            tbl_load[i] = tbl_load[i+1];
            tbl_alive[i] = tbl_alive[i+1];
          end
          tbl_used--;
          o.status = STAT_OK;
        end
      end
      ACT_LOAD_UP, ACT_LOAD_DOWN: begin
        if (hit >= 0) begin
          if (act == ACT_LOAD_UP) begin
            if (tbl_load[hit] != LoadMax) tbl_load[hit] = tbl_load[hit] + 1'b1;
          end else begin
            if (tbl_load[hit] != '0) tbl_load[hit] = tbl_load[hit] - 1'b1;
          end
          o.status = STAT_OK;
        end
      end
      ACT_SWEEP: begin
        for (int i = 0; i < tbl_used; i++) begin
          if (tbl_alive[i]) begin
            tbl_addr[keep] = tbl_addr[i];
            tbl_port[keep] = tbl_port[i];
            tbl_load[keep] = tbl_load[i];
            tbl_alive[keep] = 1'b0;
            keep++;
          end else begin
            removed++;
          end
        end
        tbl_used = keep;
        o.removed = removed[RemW-1:0];
        o.status = (removed > 0) ? STAT_OK : STAT_FAIL;
      end
      ACT_PICK: begin
        if (tbl_used > 0) begin
          low = tbl_load[0];
          for (int i = 1; i < tbl_used; i++) begin
            if (tbl_load[i] < low) low = tbl_load[i];
          end
          for (int i = 0; i < tbl_used; i++) begin
            if (o.status == STAT_FAIL && tbl_load[i] == low && tbl_alive[i]) begin
              o.status = STAT_OK;
              o.addr = tbl_addr[i];
              o.port = tbl_port[i];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic send_word(input logic [ActW-1:0] act, input logic [AddrW-1:0] addr,
                           input logic [PortW-1:0] port, input bit typed,
                           input outcome_t typed_word);
    int unsigned gap;
    outcome_t predicted;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    server_address_i <= addr;
    server_port_i <= port;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = registry_apply(act, addr, port);
    pending_q.push_back(typed ? typed_word : predicted);
    sent_count++;
    if (predicted.status == STAT_FULL) full_hits++;
    if (act == ACT_PICK && predicted.status == STAT_OK) picks_found++;
    removed_total += predicted.removed;
  endtask

  task automatic check_word();
    outcome_t want;
    checked_count++;
    if (pending_q.size() == 0) begin
      $error("unexpected result word: status %0d", status_o);
      fail_count++;
    end else begin
      want = pending_q.pop_front();
      if (status_o !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status_o);
        fail_count++;
      end
      if (picked_address_o !== want.addr) begin
        $error("picked_address: expected %h, got %h", want.addr, picked_address_o);
        fail_count++;
      end
      if (picked_port_o !== want.port) begin
        $error("picked_port: expected %h, got %h", want.port, picked_port_o);
        fail_count++;
      end
      if (removed_count_o !== want.removed) begin
        $error("removed_count: expected %0d, got %0d", want.removed, removed_count_o);
        fail_count++;
      end
    end
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall = sink_idle ? $urandom_range(0, 10) : 0;
      if (stall == 0) begin
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
      end else begin
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall - 1) @(posedge clk_i);
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
      end
      check_word();
    end
  end

  initial begin
    int unsigned roll;
    logic [ActW-1:0] act;
    server_t srv;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = ACT_PICK;
    server_address_i = '0;
    server_port_i = '0;
    tbl_used = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    // pool with shared addresses and shared ports to exercise the two-key match
    for (int i = 0; i < PoolSize; i++) begin
      pool[i].addr = $urandom;
      pool[i].port = 16'($urandom_range(0, 65535));
      if (i % 3 == 2) pool[i].addr = pool[i-1].addr;
      if (i % 5 == 4) pool[i].port = pool[i-2].port;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PlanRows[r]) begin
      send_word(PlanRows[r].act, PlanRows[r].addr, PlanRows[r].port, PlanRows[r].typed,
                PlanRows[r].want);
    end

    for (int i = 0; i <= MaxServers; i++) begin
      send_word(ACT_REGISTER, {16'hF00D, 16'(i)}, 16'(i * 3 + 1), 1'b0, NoWord);
    end
    send_word(ACT_REGISTER, 32'hF00D_000E, 16'd43, 1'b1, FailWord);

    // back-to-back burst on one load counter, then pick and step it down
    src_idle = 1'b0;
    sink_idle = 1'b0;
    for (int i = 0; i < LoadBurst; i++) begin
      send_word(ACT_LOAD_UP, 32'hA55A_5AA5, 16'h5AA5, 1'b0, NoWord);
    end
    send_word(ACT_PICK, 32'h0, 16'h0, 1'b0, NoWord);
    send_word(ACT_LOAD_DOWN, 32'hA55A_5AA5, 16'h5AA5, 1'b0, NoWord);

    for (int k = 0; k < RandomWords; k++) begin
      if (k % 150 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 28) act = ACT_REGISTER;
      else if (roll < 42) act = ACT_HEARTBEAT;
      else if (roll < 52) act = ACT_DEREGISTER;
      else if (roll < 67) act = ACT_LOAD_UP;
      else if (roll < 77) act = ACT_LOAD_DOWN;
      else if (roll < 84) act = ACT_SWEEP;
      else if (roll < 99) act = ACT_PICK;
      else act = ActReserved;
      if ($urandom_range(0, 9) == 0) begin
        srv.addr = $urandom;
        srv.port = 16'($urandom_range(0, 65535));
      end else begin
        srv = pool[$urandom_range(0, PoolSize - 1)];
      end
      send_word(act, srv.addr, srv.port, 1'b0, NoWord);
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words, checked %0d results in %0d cycles.", sent_count, checked_count,
             cycle_count);
    $display("Full-table refusals %0d, entries swept out %0d, successful picks %0d.",
             full_hits, removed_total, picks_found);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
